// ----- hdl/merged_mining_tag_parser_defines.svh -----
// assertion macros shared by the merged mining tag parser modules
// expects signals named clock and reset in the including module
`ifndef MERGED_MINING_TAG_PARSER_DEFINES_SVH
`define MERGED_MINING_TAG_PARSER_DEFINES_SVH

// property must hold at every clock edge outside reset
`define MMTP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition must never be seen outside reset
`define MMTP_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ----- hdl/mmtp_pkg.sv -----
// types and constants of the merged mining tag parser
// no dependencies
`default_nettype none

package mmtp_pkg;

   localparam int BYTE_BITS   = 8;
   localparam int WORD_BITS   = 32;
   localparam int ROOT_BYTES  = 32;
   localparam int DATA_BYTES  = 44;
   localparam int OFFSET_SAT  = 48;
   localparam int OFFSET_W    = 6;
   localparam int ROOT_WORDS  = 4;
   localparam int SLICE_BITS  = 64;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCOUNT_W    = 2;
   localparam int TAG_SAT     = 2;

   localparam int SIZE_END  = ROOT_BYTES + 4;
   localparam int NONCE_END = ROOT_BYTES + 8;

   localparam logic [1:0] LAST_WORD = 2'(ROOT_WORDS - 1);

   localparam logic CSR_TAG_MAGIC = 1'b0;
   localparam logic CSR_CHAIN_ID  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_TAG  = 2'd1,
      ST_SEVERAL = 2'd2,
      ST_SHORT   = 2'd3
   } status_type;

   typedef struct packed {
      logic [ROOT_WORDS-1:0][SLICE_BITS-1:0] root;
      logic [WORD_BITS-1:0]                  size;
      logic [WORD_BITS-1:0]                  nonce;
      logic signed [WORD_BITS-1:0]           chain;
      status_type                            status;
      logic                                  ok;
   } job_type;

endpackage

`default_nettype wire

// ----- hdl/merged_mining_tag_parser.sv -----
// Merged mining tag parser. Script bytes are taken one per cycle while the
// queue is not full; each byte costs one window compare and one capture in
// the front end. The closing item of a script pushes a summary into a
// two-entry queue, and the emitter turns each summary into four result
// transfers, holding each one while the output is stalled. Input stalls
// only while the queue is full.
// depends on mmtp_pkg, mmtp_front, mmtp_queue and mmtp_back
`default_nettype none

module merged_mining_tag_parser #(
   parameter int TAG_BYTES = 4
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [mmtp_pkg::BYTE_BITS-1:0]        req_script_byte,
   input  wire logic                                  req_has_byte,
   input  wire logic                                  req_end_of_script,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [mmtp_pkg::SLICE_BITS-1:0]            rsp_root_word,
   output logic [1:0]                                 rsp_word_number,
   output logic [mmtp_pkg::WORD_BITS-1:0]             rsp_tree_size,
   output logic [mmtp_pkg::WORD_BITS-1:0]             rsp_nonce_word,
   output logic signed [mmtp_pkg::WORD_BITS-1:0]      rsp_found_chain_id,
   output logic [1:0]                                 rsp_status,
   output logic                                       rsp_coinbase_ok,
   output logic                                       rsp_final_result,
   input  wire logic                                  csr_write_enable,
   input  wire logic                                  csr_index,
   input  wire logic [mmtp_pkg::WORD_BITS-1:0]        csr_write_data
);
   import mmtp_pkg::*;

   logic [WORD_BITS-1:0]        tag_magic_ff;
   logic signed [WORD_BITS-1:0] chain_id_ff;
   logic                        queue_full;
   logic                        push;
   job_type                     push_job;
   logic                        pop;
   logic                        pop_valid;
   job_type                     pop_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_magic_ff <= '0;
         chain_id_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TAG_MAGIC: tag_magic_ff <= csr_write_data;
            CSR_CHAIN_ID:  chain_id_ff  <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   mmtp_front #(
      .TAG_BYTES (TAG_BYTES)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_script_byte   (req_script_byte),
      .req_has_byte      (req_has_byte),
      .req_end_of_script (req_end_of_script),
      .tag_magic         (tag_magic_ff),
      .our_chain_id      (chain_id_ff),
      .queue_full        (queue_full),
      .push              (push),
      .push_job          (push_job)
   );

   mmtp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_job   (pop_job)
   );

   mmtp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .job_valid          (pop_valid),
      .job                (pop_job),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_root_word      (rsp_root_word),
      .rsp_word_number    (rsp_word_number),
      .rsp_tree_size      (rsp_tree_size),
      .rsp_nonce_word     (rsp_nonce_word),
      .rsp_found_chain_id (rsp_found_chain_id),
      .rsp_status         (rsp_status),
      .rsp_coinbase_ok    (rsp_coinbase_ok),
      .rsp_final_result   (rsp_final_result)
   );

endmodule

`default_nettype wire

// ----- hdl/mmtp_front.sv -----
// front end: byte window match, tag counting and field capture
// depends on mmtp_pkg; pushes one summary per script into the queue
`default_nettype none

module mmtp_front #(
   parameter int TAG_BYTES = 4
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [mmtp_pkg::BYTE_BITS-1:0]     req_script_byte,
   input  wire logic                               req_has_byte,
   input  wire logic                               req_end_of_script,
   input  wire logic [mmtp_pkg::WORD_BITS-1:0]     tag_magic,
   input  wire logic signed [mmtp_pkg::WORD_BITS-1:0] our_chain_id,
   input  wire logic                               queue_full,
   output logic                                    push,
   output mmtp_pkg::job_type                       push_job
);
   import mmtp_pkg::*;

   localparam int WIN    = BYTE_BITS * TAG_BYTES;
   localparam int SEEN_W = (TAG_BYTES > 1) ? $clog2(TAG_BYTES) : 1;
   localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(TAG_BYTES - 1);

   logic [WIN-1:0]                        window_ff, window_in;
   logic [WIN+BYTE_BITS-1:0]              shifted;
   logic [WIN+WORD_BITS-1:0]              magic_ext;
   logic [WIN-1:0]                        magic_win;
   logic [SEEN_W-1:0]                     seen_ff, seen_in;
   logic [1:0]                            tags_ff, tags_in;
   logic [OFFSET_W-1:0]                   offset_ff, offset_in;
   logic [ROOT_WORDS-1:0][SLICE_BITS-1:0] root_ff, root_in;
   logic [WORD_BITS-1:0]                  size_ff, size_in;
   logic [WORD_BITS-1:0]                  nonce_ff, nonce_in;
   logic signed [WORD_BITS-1:0]           chain_ff, chain_in;
   logic                                  hit;
   logic                                  accept;
   status_type                            status;

   assign accept    = req_valid && !queue_full;
   assign req_stall = queue_full;
   assign push      = accept && req_end_of_script;

   assign shifted   = {window_ff, req_script_byte};
   assign magic_ext = {{WIN{1'b0}}, tag_magic};
   assign magic_win = magic_ext[WIN-1:0];
   assign hit       = (seen_ff == SEEN_MAX) && (shifted[WIN-1:0] == magic_win);

   always_comb begin
      window_in = window_ff;
      seen_in   = seen_ff;
      tags_in   = tags_ff;
      offset_in = offset_ff;
      root_in   = root_ff;
      size_in   = size_ff;
      nonce_in  = nonce_ff;
      chain_in  = chain_ff;
      if (req_has_byte) begin
         window_in = shifted[WIN-1:0];
         if (seen_ff != SEEN_MAX) begin
            seen_in = seen_ff + 1'b1;
         end
         if (tags_ff != 2'd0) begin
            if (offset_ff < OFFSET_W'(ROOT_BYTES)) begin
               root_in[offset_ff[4:3]] = {root_ff[offset_ff[4:3]][SLICE_BITS-BYTE_BITS-1:0],
                                          req_script_byte};
            end else if (offset_ff < OFFSET_W'(SIZE_END)) begin
               size_in[{offset_ff[1:0], 3'b000} +: BYTE_BITS] = req_script_byte;
            end else if (offset_ff < OFFSET_W'(NONCE_END)) begin
               nonce_in[{offset_ff[1:0], 3'b000} +: BYTE_BITS] = req_script_byte;
            end else if (offset_ff < OFFSET_W'(DATA_BYTES)) begin
               chain_in[{offset_ff[1:0], 3'b000} +: BYTE_BITS] = req_script_byte;
            end
            if (offset_ff < OFFSET_W'(OFFSET_SAT)) begin
               offset_in = offset_ff + 1'b1;
            end
         end
         if (hit && (tags_ff < 2'(TAG_SAT))) begin
            tags_in = tags_ff + 1'b1;
         end
      end
   end

   always_comb begin
      if (tags_in == 2'd0) begin
         status = ST_NO_TAG;
      end else if (tags_in >= 2'(TAG_SAT)) begin
         status = ST_SEVERAL;
      end else if (offset_in < OFFSET_W'(DATA_BYTES)) begin
         status = ST_SHORT;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      push_job.root   = root_in;
      push_job.size   = size_in;
      push_job.nonce  = nonce_in;
      push_job.chain  = chain_in;
      push_job.status = status;
      push_job.ok     = (status != ST_OK) || (chain_in == our_chain_id);
   end

   // per-script control state, cleared after the closing item
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         seen_ff   <= '0;
         tags_ff   <= '0;
         offset_ff <= '0;
      end else if (accept) begin
         if (req_end_of_script) begin
            window_ff <= '0;
            seen_ff   <= '0;
            tags_ff   <= '0;
            offset_ff <= '0;
         end else begin
            window_ff <= window_in;
            seen_ff   <= seen_in;
            tags_ff   <= tags_in;
            offset_ff <= offset_in;
         end
      end
   end

   // captured fields are fully rewritten before any ok summary uses them
   always_ff @(posedge clock) begin
      if (accept) begin
         root_ff  <= root_in;
         size_ff  <= size_in;
         nonce_ff <= nonce_in;
         chain_ff <= chain_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/mmtp_queue.sv -----
// two-entry queue of script summaries between front end and emitter
// depends on mmtp_pkg and the assertion macro header
`default_nettype none

`include "merged_mining_tag_parser_defines.svh"

module mmtp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire mmtp_pkg::job_type push_job,
   output logic                   full,
   input  wire logic              pop,
   output logic                   pop_valid,
   output mmtp_pkg::job_type      pop_job
);
   import mmtp_pkg::*;

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == QCOUNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   `MMTP_NEVER(a_no_push_full, push && full && !pop, "queue overflow")
   `MMTP_NEVER(a_no_pop_empty, pop && !pop_valid, "queue underflow")
   `MMTP_ASSERT(a_count_range, count_ff <= QCOUNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

`default_nettype wire

// ----- hdl/mmtp_back.sv -----
// emitter: turns one script summary into four result transfers
// depends on mmtp_pkg and the assertion macro header
`default_nettype none

`include "merged_mining_tag_parser_defines.svh"

module mmtp_back (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  job_valid,
   input  wire mmtp_pkg::job_type                     job,
   output logic                                       pop,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [mmtp_pkg::SLICE_BITS-1:0]            rsp_root_word,
   output logic [1:0]                                 rsp_word_number,
   output logic [mmtp_pkg::WORD_BITS-1:0]             rsp_tree_size,
   output logic [mmtp_pkg::WORD_BITS-1:0]             rsp_nonce_word,
   output logic signed [mmtp_pkg::WORD_BITS-1:0]      rsp_found_chain_id,
   output logic [1:0]                                 rsp_status,
   output logic                                       rsp_coinbase_ok,
   output logic                                       rsp_final_result
);
   import mmtp_pkg::*;

   job_type    cur_ff;
   logic       active_ff, active_in;
   logic [1:0] word_ff, word_in;
   logic       xfer;
   logic       last_xfer;
   logic       good;

   assign xfer      = active_ff && !rsp_stall;
   assign last_xfer = xfer && (word_ff == LAST_WORD);
   assign pop       = job_valid && (!active_ff || last_xfer);

   always_comb begin
      active_in = active_ff;
      word_in   = word_ff;
      if (pop) begin
         active_in = 1'b1;
         word_in   = '0;
      end else if (last_xfer) begin
         active_in = 1'b0;
         word_in   = '0;
      end else if (xfer) begin
         word_in = word_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         word_ff   <= '0;
      end else begin
         active_ff <= active_in;
         word_ff   <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= job;
      end
   end

   // failed parses report zero data
   assign good               = (cur_ff.status == ST_OK);
   assign rsp_valid          = active_ff;
   assign rsp_root_word      = good ? cur_ff.root[word_ff] : '0;
   assign rsp_word_number    = word_ff;
   assign rsp_tree_size      = good ? cur_ff.size : '0;
   assign rsp_nonce_word     = good ? cur_ff.nonce : '0;
   assign rsp_found_chain_id = good ? cur_ff.chain : '0;
   assign rsp_status         = cur_ff.status;
   assign rsp_coinbase_ok    = cur_ff.ok;
   assign rsp_final_result   = (word_ff == LAST_WORD);

   `MMTP_ASSERT(a_word_step, xfer && (word_ff != LAST_WORD) |=> active_ff && (word_ff == $past(word_ff) + 2'd1), "word number did not advance")
   `MMTP_ASSERT(a_idle_word, !active_ff |-> (word_ff == 2'd0), "idle emitter holds a word number")
   `MMTP_ASSERT(a_stall_hold, active_ff && rsp_stall |=> active_ff && $stable(word_ff), "stalled result moved")

endmodule

`default_nettype wire

// ----- sim/merged_mining_tag_parser_test.sv -----
// testbench for merged_mining_tag_parser: streams coinbase scripts, predicts the four
// result slices of every script and checks them field by field
// depends on mmtp_pkg and the merged_mining_tag_parser rtl
`timescale 1ns / 1ps

module merged_mining_tag_parser_test;
   import mmtp_pkg::*;

   localparam int TAG_LEN = 4;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD_CYCLES = 400;

   typedef struct {
      logic [SLICE_BITS-1:0]       root;
      logic [1:0]                  number;
      logic [WORD_BITS-1:0]        size;
      logic [WORD_BITS-1:0]        nonce;
      logic signed [WORD_BITS-1:0] chain;
      status_type                  status;
      logic                        ok;
      logic                        last;
   } tag_slice_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   wire req_stall;
   logic [BYTE_BITS-1:0] req_script_byte = '0;
   logic req_has_byte = 1'b0;
   logic req_end_of_script = 1'b0;
   wire rsp_valid;
   logic rsp_stall = 1'b0;
   wire [SLICE_BITS-1:0] rsp_root_word;
   wire [1:0] rsp_word_number;
   wire [WORD_BITS-1:0] rsp_tree_size;
   wire [WORD_BITS-1:0] rsp_nonce_word;
   wire signed [WORD_BITS-1:0] rsp_found_chain_id;
   wire [1:0] rsp_status;
   wire rsp_coinbase_ok;
   wire rsp_final_result;
   logic csr_write_enable = 1'b0;
   logic csr_index = 1'b0;
   logic [WORD_BITS-1:0] csr_write_data = '0;

   // predicted parser state and register copies
   logic [WORD_BITS-1:0] tag_magic_reg = '0;
   logic [WORD_BITS-1:0] our_chain_reg = '0;
   logic [8*(TAG_LEN-1)-1:0] window_bytes = '0;
   logic [1:0] window_fill = '0;
   logic [1:0] tag_hits = '0;
   logic [OFFSET_W-1:0] data_offset = '0;
   logic [SLICE_BITS-1:0] root_words [ROOT_WORDS] = '{default: '0};
   logic [WORD_BITS-1:0] size_le = '0;
   logic [WORD_BITS-1:0] nonce_le = '0;
   logic [WORD_BITS-1:0] chain_le = '0;

   tag_slice_type predicted_slices[$];
   logic [BYTE_BITS-1:0] script_buf[$];
   int error_count = 0;

   bit sender_gaps = 1'b1;
   logic receiver_gaps = 1'b1;
   int hold_len = 0;
   int hold_id = 0;
   int hold_seen = 0;
   int hold_left = 0;

   merged_mining_tag_parser #(.TAG_BYTES(TAG_LEN)) DUT (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("merged_mining_tag_parser_test: FAIL");
      $finish;
   end

   task automatic parse_script_item(logic [BYTE_BITS-1:0] b, logic has, logic last);
      logic [8*TAG_LEN-1:0] window;
      int pos;
      status_type st;
      logic good;
      logic accept;
      tag_slice_type s;
      if (has) begin
         window = {window_bytes, b};
         pos = int'(data_offset);
         if (tag_hits != 2'd0) begin
            if (pos < ROOT_BYTES)
               root_words[pos / 8] = {root_words[pos / 8][SLICE_BITS-9:0], b};
            else if (pos < SIZE_END)
               size_le[(pos - ROOT_BYTES) * 8 +: 8] = b;
            else if (pos < NONCE_END)
               nonce_le[(pos - SIZE_END) * 8 +: 8] = b;
            else if (pos < DATA_BYTES)
               chain_le[(pos - NONCE_END) * 8 +: 8] = b;
            if (data_offset < OFFSET_W'(OFFSET_SAT)) data_offset++;
         end
         // the byte completing the first tag is not data
         if (window_fill == 2'(TAG_LEN - 1) && window == tag_magic_reg &&
             tag_hits < 2'(TAG_SAT))
            tag_hits++;
         window_bytes = window[8*(TAG_LEN-1)-1:0];
         if (window_fill < 2'(TAG_LEN - 1)) window_fill++;
      end
      if (last) begin
         if (tag_hits == 2'd0) st = ST_NO_TAG;
         else if (tag_hits >= 2'(TAG_SAT)) st = ST_SEVERAL;
         else if (data_offset < OFFSET_W'(DATA_BYTES)) st = ST_SHORT;
         else st = ST_OK;
         good = (st == ST_OK);
         accept = !good || chain_le == our_chain_reg;
         for (int k = 0; k < ROOT_WORDS; k++) begin
            s.root = good ? root_words[k] : '0;
            s.number = 2'(k);
            s.size = good ? size_le : '0;
            s.nonce = good ? nonce_le : '0;
            s.chain = good ? chain_le : '0;
            s.status = st;
            s.ok = accept;
            s.last = (2'(k) == LAST_WORD);
            predicted_slices.push_back(s);
         end
         window_bytes = '0;
         window_fill = '0;
         tag_hits = '0;
         data_offset = '0;
         root_words = '{default: '0};
         size_le = '0;
         nonce_le = '0;
         chain_le = '0;
      end
   endtask

   task automatic send_item(logic [BYTE_BITS-1:0] b, logic has, logic last);
      while (sender_gaps && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         req_script_byte <= 8'($urandom);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_script_byte <= b;
      req_has_byte <= has;
      req_end_of_script <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_script_item(b, has, last);
   endtask

   task automatic add_random_bytes(int n);
      repeat (n) script_buf.push_back(8'($urandom));
   endtask

   task automatic add_tag();
      for (int i = TAG_LEN - 1; i >= 0; i--) script_buf.push_back(tag_magic_reg[8*i +: 8]);
   endtask

   task automatic add_word_le(logic [WORD_BITS-1:0] w);
      for (int i = 0; i < 4; i++) script_buf.push_back(w[8*i +: 8]);
   endtask

   task automatic add_payload(logic [WORD_BITS-1:0] chain);
      add_random_bytes(ROOT_BYTES);
      add_word_le($urandom);
      add_word_le($urandom);
      add_word_le(chain);
   endtask

   // empty items are sprinkled in; the close is either the last byte or an empty item
   task automatic send_script(bit empty_close, int empty_pct);
      int n;
      n = script_buf.size();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < empty_pct) send_item(8'($urandom), 1'b0, 1'b0);
         send_item(script_buf[i], 1'b1, !empty_close && i == n - 1);
      end
      if (empty_close || n == 0) send_item(8'($urandom), 1'b0, 1'b1);
      script_buf.delete();
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_slices.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [WORD_BITS-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_TAG_MAGIC) tag_magic_reg = value;
      else our_chain_reg = value;
      @(posedge clock);
   endtask

   // reset values: zero tag, zero chain id
   task automatic test_reset_state();
      send_script(1'b1, 0);
      repeat (3) script_buf.push_back(8'h00);
      send_script(1'b0, 0);
      repeat (4) script_buf.push_back(8'h00);
      send_script(1'b0, 0);
      repeat (5) script_buf.push_back(8'h00);
      send_script(1'b1, 0);
      wait_for_results();
   endtask

   task automatic test_clean_parse();
      write_csr(CSR_TAG_MAGIC, 32'h5A3C_96E1);
      write_csr(CSR_CHAIN_ID, 32'h7FFF_FFFF);
      add_random_bytes(2);
      add_tag();
      for (int i = 0; i < ROOT_BYTES; i++) script_buf.push_back(i[0] ? 8'hFF : 8'h00);
      add_word_le(32'hFFFF_FFFF);
      add_word_le(32'h0000_0000);
      add_word_le(32'h7FFF_FFFF);
      send_script(1'b0, 0);
      add_tag();
      add_payload(32'h8000_0000);
      add_random_bytes(5);
      send_script(1'b1, 20);
      wait_for_results();
      write_csr(CSR_CHAIN_ID, 32'h8000_0000);
      add_tag();
      add_payload(32'h8000_0000);
      send_script(1'b0, 0);
      wait_for_results();
   endtask

   task automatic test_status_priority();
      write_csr(CSR_TAG_MAGIC, 32'hA5A5_A5A5);
      write_csr(CSR_CHAIN_ID, 32'hFFFF_FFFF);
      // overlapping tags
      repeat (6) script_buf.push_back(8'hA5);
      send_script(1'b0, 0);
      add_tag();
      repeat (DATA_BYTES - 1) script_buf.push_back(8'h3C);
      send_script(1'b0, 0);
      add_tag();
      send_script(1'b1, 0);
      add_tag();
      add_tag();
      add_random_bytes(10);
      send_script(1'b0, 0);
      repeat (12) script_buf.push_back(8'h00);
      send_script(1'b0, 0);
      // second tag after the data bytes
      add_tag();
      add_payload(32'hFFFF_FFFF);
      add_tag();
      send_script(1'b0, 0);
      add_tag();
      add_payload(32'hFFFF_FFFF);
      send_script(1'b1, 10);
      wait_for_results();
   endtask

   task automatic test_backpressure();
      write_csr(CSR_TAG_MAGIC, $urandom);
      hold_len <= LONG_HOLD_CYCLES;
      hold_id <= hold_id + 1;
      sender_gaps = 1'b0;
      repeat (12) begin
         add_random_bytes($urandom_range(1, 5));
         send_script(1'b0, 0);
      end
      add_tag();
      add_payload(our_chain_reg);
      send_script(1'b0, 0);
      wait_for_results();
      sender_gaps = 1'b1;
   endtask

   task automatic test_random();
      int items;
      int script_no;
      int kind;
      int n;
      bit empty_close;
      logic [WORD_BITS-1:0] value;
      items = 0;
      script_no = 0;
      while (items < 250) begin
         if (script_no % 5 == 0) begin
            wait_for_results();
            case ($urandom_range(5))
               0: value = '0;
               1: value = '1;
               2: value = {4{8'($urandom)}};
               3: value = {2{16'($urandom)}};
               default: value = $urandom;
            endcase
            write_csr(CSR_TAG_MAGIC, value);
            case ($urandom_range(5))
               0: value = '0;
               1: value = 32'h7FFF_FFFF;
               2: value = 32'h8000_0000;
               3: value = '1;
               default: value = $urandom;
            endcase
            write_csr(CSR_CHAIN_ID, value);
         end
         // first scripts run with no idling on either side
         sender_gaps = (script_no >= 3);
         receiver_gaps <= (script_no >= 3);
         kind = $urandom_range(99);
         add_random_bytes($urandom_range(0, 6));
         if (kind < 55) begin
            add_tag();
            add_payload($urandom_range(1) ? our_chain_reg : $urandom);
            add_random_bytes($urandom_range(0, 4));
         end else if (kind < 70) begin
            add_tag();
            add_random_bytes($urandom_range(0, DATA_BYTES - 1));
         end else if (kind < 80) begin
            add_random_bytes($urandom_range(0, 10));
         end else if (kind < 92) begin
            add_tag();
            add_random_bytes($urandom_range(0, 50));
            add_tag();
            add_random_bytes($urandom_range(0, 8));
         end else begin
            add_tag();
            add_payload($urandom_range(1) ? our_chain_reg : $urandom);
            add_random_bytes($urandom_range(10, 40));
         end
         empty_close = ($urandom_range(99) < 30);
         n = script_buf.size();
         items += (empty_close || n == 0) ? n + 1 : n;
         send_script(empty_close, 4);
         script_no++;
      end
   endtask

   always @(posedge clock) begin
      if (hold_seen != hold_id) begin
         hold_seen <= hold_id;
         hold_left <= hold_len;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= receiver_gaps && ($urandom_range(99) < 14);
      end
   end

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      tag_slice_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_slices.size() == 0) begin
            $error("result transfer with nothing expected, word_number %0d", rsp_word_number);
            error_count++;
         end else begin
            want = predicted_slices.pop_front();
            check_field("root_word", want.root, rsp_root_word);
            check_field("word_number", 64'(want.number), 64'(rsp_word_number));
            check_field("tree_size", 64'(want.size), 64'(rsp_tree_size));
            check_field("nonce_word", 64'(want.nonce), 64'(rsp_nonce_word));
            check_field("found_chain_id", 64'(want.chain), 64'(rsp_found_chain_id));
            check_field("status", 64'(want.status), 64'(rsp_status));
            check_field("coinbase_ok", 64'(want.ok), 64'(rsp_coinbase_ok));
            check_field("final_result", 64'(want.last), 64'(rsp_final_result));
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_clean_parse();
      test_status_priority();
      test_backpressure();
      test_random();
      wait_for_results();
      if (error_count == 0 && predicted_slices.size() == 0) begin
         $display("merged_mining_tag_parser_test: PASS");
      end else begin
         if (predicted_slices.size() != 0)
            $error("%0d expected result transfers never arrived", predicted_slices.size());
         $display("merged_mining_tag_parser_test: FAIL");
      end
      $finish;
   end

endmodule
